>>> rtl/gpce_pkg.sv
`default_nettype none

package gpce_pkg;

	// Configuration port layout.
	localparam int CFG_DATA_W  = 48;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_SCALE_X = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_SCALE_Y = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y    = 3'd4;

	// Field widths.
	localparam int SCALE_W  = 32;
	localparam int OFFSET_W = 48;
	localparam int COORD_W  = 32;
	localparam int COUNT_W  = 16;

	// Reset values of the scale and offset registers.
	localparam logic [SCALE_W-1:0]  INV_SCALE_RESET = 32'h0001_0000;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET    = 48'h0;

	// Fixed-point datapath. The cell term (2*cell+1) fits in 34 bits for any
	// index width up to 32 and is split at bit 17 into two partial products.
	localparam int NORM_W  = 34;
	localparam int SPLIT   = 17;
	localparam int PART_W  = 49;
	localparam int PROD_W  = 53;
	localparam int SUM_W   = 55;

	localparam logic [PART_W-1:0] PROD_HUGE  = 49'h4_0000_0000;
	localparam logic [PROD_W-1:0] PROD_CLAMP = 53'h8_0000_0000_0000;
	localparam logic [SUM_W-1:0]  ROUND_HALF = 55'h1_0000;
	localparam logic [SUM_W-1:0]  POS_LIMIT  = 55'h7FFF_FFFF;
	localparam logic [SUM_W-1:0]  NEG_LIMIT  = 55'h8000_0000;

	localparam int QUEUE_DEPTH = 4;

	// Flags that travel with each emitted point.
	typedef struct packed {
		logic first;
		logic last;
	} emit_flags_t;

	// Magnitude of a signed scale; the most negative value maps to 2^31.
	function automatic logic [SCALE_W-1:0] abs_scale(input logic [SCALE_W-1:0] v);
		abs_scale = v[SCALE_W-1] ? (~v + SCALE_W'(1)) : v;
	endfunction

	// Joins the partial products, applies the sign and adds the offset in Q.17.
	function automatic logic signed [SUM_W-1:0] combine_sum(
		input logic [PART_W-1:0]   hi,
		input logic [PART_W-1:0]   lo,
		input logic                neg,
		input logic [OFFSET_W-1:0] off
	);
		logic [PROD_W-1:0]        prod;
		logic signed [SUM_W-1:0]  sprod;
		logic signed [SUM_W-1:0]  soff;
		if (hi > PROD_HUGE) begin
			prod = PROD_CLAMP;
		end else begin
			prod = (PROD_W'(hi) << SPLIT) + PROD_W'(lo);
		end
		sprod = $signed(SUM_W'(prod));
		if (neg) begin
			sprod = -sprod;
		end
		soff = SUM_W'($signed({off, 1'b0}));
		combine_sum = sprod + soff;
	endfunction

	// Rounds a Q.17 value half away from zero and saturates it to 32 bits.
	function automatic logic [COORD_W-1:0] round_sat(input logic [SUM_W-1:0] sum);
		logic [SUM_W-1:0] mag;
		logic [SUM_W-1:0] rmag;
		mag  = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
		rmag = (mag + ROUND_HALF) >> SPLIT;
		if (!sum[SUM_W-1]) begin
			round_sat = (rmag > POS_LIMIT) ? POS_LIMIT[COORD_W-1:0] : rmag[COORD_W-1:0];
		end else if (rmag > NEG_LIMIT) begin
			round_sat = NEG_LIMIT[COORD_W-1:0];
		end else begin
			round_sat = ~rmag[COORD_W-1:0] + COORD_W'(1);
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/gpce_front.sv
`default_nettype none

module gpce_front import gpce_pkg::*; #(
	parameter int INDEX_BITS = 20,
	parameter int COL_W      = 12,
	parameter int GW_W       = 13
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [INDEX_BITS-1:0] cell_index,
	input  wire logic                  path_end,
	input  wire logic [GW_W-1:0]       grid_width,
	output logic                       push_valid,
	input  wire logic                  push_full,
	output logic [COL_W-1:0]           push_col,
	output logic [INDEX_BITS-1:0]      push_row,
	output emit_flags_t                push_flags
);

	localparam int CNT_W  = $clog2(INDEX_BITS);
	localparam int PROD_X = COL_W + INDEX_BITS + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_CROSS,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     end_q;
	logic                     first_q;
	logic                     held_valid_q;

	logic [INDEX_BITS-1:0]    div_q;
	logic [COL_W-1:0]         rem_q;
	logic [COL_W-1:0]         held_col_q;
	logic [INDEX_BITS-1:0]    held_row_q;
	logic [COL_W-1:0]         kept_col_q;
	logic [INDEX_BITS-1:0]    kept_row_q;
	logic signed [PROD_X-1:0] prod_a_q;
	logic signed [PROD_X-1:0] prod_b_q;

	logic [COL_W:0]           gw_ext;
	logic [COL_W:0]           trial;
	logic [COL_W:0]           diff;
	logic                     ge;
	logic signed [COL_W:0]      ax;
	logic signed [COL_W:0]      bx;
	logic signed [INDEX_BITS:0] ay;
	logic signed [INDEX_BITS:0] by;
	logic                     keep_mid;
	logic                     push_ok;

	// One restoring division step: the remainder takes the next dividend bit.
	assign gw_ext = (COL_W+1)'(grid_width);
	assign trial  = {rem_q, div_q[INDEX_BITS-1]};
	assign ge     = (trial >= gw_ext);
	assign diff   = trial - gw_ext;

	// Cross product terms against the last kept point; div_q and rem_q now
	// hold the row and column of the current beat.
	assign ax = $signed({1'b0, held_col_q}) - $signed({1'b0, kept_col_q});
	assign bx = $signed({1'b0, rem_q}) - $signed({1'b0, kept_col_q});
	assign ay = $signed({1'b0, held_row_q}) - $signed({1'b0, kept_row_q});
	assign by = $signed({1'b0, div_q}) - $signed({1'b0, kept_row_q});

	assign keep_mid = held_valid_q && (prod_a_q != prod_b_q);
	assign in_ready = (state_q == ST_IDLE);
	assign push_ok  = push_valid && !push_full;

	// The held point goes out from the decide state; every other push
	// carries the current point.
	always_comb begin
		push_valid       = 1'b0;
		push_col         = rem_q;
		push_row         = div_q;
		push_flags.first = 1'b0;
		push_flags.last  = end_q;
		unique case (state_q)
			ST_DECIDE: begin
				if (first_q) begin
					push_valid       = 1'b1;
					push_flags.first = 1'b1;
				end else if (keep_mid) begin
					push_valid      = 1'b1;
					push_col        = held_col_q;
					push_row        = held_row_q;
					push_flags.last = 1'b0;
				end
			end
			ST_FINISH: begin
				push_valid = end_q;
			end
			default: begin
				push_valid = 1'b0;
			end
		endcase
	end

	// Sequencer: accept, divide, form the cross product, then emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			end_q        <= 1'b0;
			first_q      <= 1'b1;
			held_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						end_q   <= path_end;
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(INDEX_BITS - 1)) begin
						state_q <= ST_CROSS;
					end
				end
				ST_CROSS: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (first_q) begin
						if (push_ok) begin
							held_valid_q <= 1'b0;
							first_q      <= end_q;
							state_q      <= ST_IDLE;
						end
					end else if (keep_mid) begin
						if (push_ok) begin
							state_q <= ST_FINISH;
						end
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (end_q) begin
						if (push_ok) begin
							held_valid_q <= 1'b0;
							first_q      <= 1'b1;
							state_q      <= ST_IDLE;
						end
					end else begin
						held_valid_q <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: divider, products, held and kept points.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			div_q <= cell_index;
			rem_q <= '0;
		end else if (state_q == ST_DIVIDE) begin
			div_q <= {div_q[INDEX_BITS-2:0], ge};
			rem_q <= ge ? diff[COL_W-1:0] : trial[COL_W-1:0];
		end

		if (state_q == ST_CROSS) begin
			prod_a_q <= PROD_X'(ax) * PROD_X'(by);
			prod_b_q <= PROD_X'(ay) * PROD_X'(bx);
		end

		if (push_ok) begin
			kept_col_q <= push_col;
			kept_row_q <= push_row;
		end

		if (state_q == ST_FINISH && !end_q) begin
			held_col_q <= rem_q;
			held_row_q <= div_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/gpce_fifo.sv
`default_nettype none

module gpce_fifo #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> rtl/gpce_back.sv
`default_nettype none

module gpce_back import gpce_pkg::*; #(
	parameter int INDEX_BITS = 20,
	parameter int COL_W      = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	output logic                       q_pop,
	input  wire logic [COL_W-1:0]      q_col,
	input  wire logic [INDEX_BITS-1:0] q_row,
	input  wire emit_flags_t           q_flags,
	input  wire logic [SCALE_W-1:0]    inv_scale_x,
	input  wire logic [SCALE_W-1:0]    inv_scale_y,
	input  wire logic [OFFSET_W-1:0]   offset_x,
	input  wire logic [OFFSET_W-1:0]   offset_y,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [COORD_W-1:0]  coord_x,
	output logic signed [COORD_W-1:0]  coord_y,
	output logic [COUNT_W-1:0]         point_count,
	output logic                       last_point
);

	logic                    en;
	logic [NORM_W-1:0]       norm_x;
	logic [NORM_W-1:0]       norm_y;
	logic [SCALE_W-1:0]      mag_x;
	logic [SCALE_W-1:0]      mag_y;
	logic [COUNT_W-1:0]      count_next;
	logic [COUNT_W-1:0]      count_q;

	logic                    valid_s1;
	logic [PART_W-1:0]       hi_x_s1;
	logic [PART_W-1:0]       lo_x_s1;
	logic [PART_W-1:0]       hi_y_s1;
	logic [PART_W-1:0]       lo_y_s1;
	logic                    neg_x_s1;
	logic                    neg_y_s1;
	logic [COUNT_W-1:0]      count_s1;
	logic                    last_s1;

	logic                    valid_s2;
	logic signed [SUM_W-1:0] sum_x_s2;
	logic signed [SUM_W-1:0] sum_y_s2;
	logic [COUNT_W-1:0]      count_s2;
	logic                    last_s2;

	// The whole pipe advances unless a finished beat waits at the output.
	assign en    = !out_valid || out_ready;
	assign q_pop = en && q_valid;

	assign norm_x = NORM_W'({q_col, 1'b1});
	assign norm_y = NORM_W'({q_row, 1'b1});
	assign mag_x  = abs_scale(inv_scale_x);
	assign mag_y  = abs_scale(inv_scale_y);

	// Running count restarts on the first point of each path and saturates.
	always_comb begin
		if (q_flags.first) begin
			count_next = COUNT_W'(1);
		end else if (count_q == '1) begin
			count_next = count_q;
		end else begin
			count_next = count_q + COUNT_W'(1);
		end
	end

	// Valid bits and the point counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			if (q_valid) begin
				count_q <= count_next;
			end
			valid_s1  <= q_valid;
			valid_s2  <= valid_s1;
			out_valid <= valid_s2;
		end
	end

	// Stage 1: partial products of the cell term and the scale magnitude.
	// Stage 2: combine, apply sign and add the offset.
	// Stage 3: round and saturate into the output register.
	always_ff @(posedge clk) begin
		if (en) begin
			hi_x_s1  <= PART_W'(norm_x[NORM_W-1:SPLIT]) * PART_W'(mag_x);
			lo_x_s1  <= PART_W'(norm_x[SPLIT-1:0]) * PART_W'(mag_x);
			hi_y_s1  <= PART_W'(norm_y[NORM_W-1:SPLIT]) * PART_W'(mag_y);
			lo_y_s1  <= PART_W'(norm_y[SPLIT-1:0]) * PART_W'(mag_y);
			neg_x_s1 <= inv_scale_x[SCALE_W-1];
			neg_y_s1 <= inv_scale_y[SCALE_W-1];
			count_s1 <= count_next;
			last_s1  <= q_flags.last;

			sum_x_s2 <= combine_sum(hi_x_s1, lo_x_s1, neg_x_s1, offset_x);
			sum_y_s2 <= combine_sum(hi_y_s1, lo_y_s1, neg_y_s1, offset_y);
			count_s2 <= count_s1;
			last_s2  <= last_s1;

			coord_x     <= $signed(round_sat(sum_x_s2));
			coord_y     <= $signed(round_sat(sum_y_s2));
			point_count <= count_s2;
			last_point  <= last_s2;
		end
	end

endmodule

`default_nettype wire

>>> rtl/grid_path_corner_extract_denorm.sv
`default_nettype none

// Channel  Handshake               Payload
// -------  ----------------------  ------------------------------------------------
// in       in_valid / in_ready     cell_index, path_end
// out      out_valid / out_ready   coord_x, coord_y, point_count, last_point
// cfg      cfg_we (no wait)        cfg_index, cfg_data
//
// The front takes a new beat only when it is through with the last one; the first
// point of a path skips the finish step. The index is split by a restoring divider
// that retires one quotient bit per cycle, and the front is not ready meanwhile.
// Kept points pass through a four-entry queue into a three-stage back end.
// Reset clears the path state so that the next beat starts a new path.
// A stalled output holds the back end; the front stalls only when the queue is full.

module grid_path_corner_extract_denorm import gpce_pkg::*; #(
	parameter int INDEX_BITS     = 20,
	parameter int MAX_GRID_WIDTH = 4096
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [INDEX_BITS-1:0]  cell_index,
	input  wire logic                   path_end,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [COORD_W-1:0]   coord_x,
	output logic signed [COORD_W-1:0]   coord_y,
	output logic [COUNT_W-1:0]          point_count,
	output logic                        last_point,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int COL_W   = $clog2(MAX_GRID_WIDTH);
	localparam int GW_W    = $clog2(MAX_GRID_WIDTH + 1);
	localparam int FLAGS_W = $bits(emit_flags_t);
	localparam int ENTRY_W = FLAGS_W + INDEX_BITS + COL_W;

	logic [GW_W-1:0]       grid_width_q;
	logic [SCALE_W-1:0]    inv_scale_x_q;
	logic [SCALE_W-1:0]    inv_scale_y_q;
	logic [OFFSET_W-1:0]   offset_x_q;
	logic [OFFSET_W-1:0]   offset_y_q;
	logic [GW_W-1:0]       gw_clamped;

	logic                  push_valid;
	logic                  push_full;
	logic [COL_W-1:0]      push_col;
	logic [INDEX_BITS-1:0] push_row;
	emit_flags_t           push_flags;
	logic [ENTRY_W-1:0]    pop_data;
	logic                  q_valid;
	logic                  q_pop;

	// A zero width reads as one and widths past the maximum are clipped.
	always_comb begin
		if (cfg_data[31:0] == 32'd0) begin
			gw_clamped = GW_W'(1);
		end else if (cfg_data[31:0] > 32'(MAX_GRID_WIDTH)) begin
			gw_clamped = GW_W'(MAX_GRID_WIDTH);
		end else begin
			gw_clamped = cfg_data[GW_W-1:0];
		end
	end

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GW_W'(1);
			inv_scale_x_q <= INV_SCALE_RESET;
			inv_scale_y_q <= INV_SCALE_RESET;
			offset_x_q    <= OFFSET_RESET;
			offset_y_q    <= OFFSET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= gw_clamped;
				REG_INV_SCALE_X: inv_scale_x_q <= cfg_data[SCALE_W-1:0];
				REG_INV_SCALE_Y: inv_scale_y_q <= cfg_data[SCALE_W-1:0];
				REG_OFFSET_X:    offset_x_q    <= cfg_data[OFFSET_W-1:0];
				REG_OFFSET_Y:    offset_y_q    <= cfg_data[OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gpce_front #(
		.INDEX_BITS (INDEX_BITS),
		.COL_W      (COL_W),
		.GW_W       (GW_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cell_index (cell_index),
		.path_end   (path_end),
		.grid_width (grid_width_q),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_col   (push_col),
		.push_row   (push_row),
		.push_flags (push_flags)
	);

	gpce_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data ({push_flags, push_row, push_col}),
		.full      (push_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.not_empty (q_valid)
	);

	gpce_back #(
		.INDEX_BITS (INDEX_BITS),
		.COL_W      (COL_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_col       (pop_data[COL_W-1:0]),
		.q_row       (pop_data[COL_W +: INDEX_BITS]),
		.q_flags     (emit_flags_t'(pop_data[ENTRY_W-1 -: FLAGS_W])),
		.inv_scale_x (inv_scale_x_q),
		.inv_scale_y (inv_scale_y_q),
		.offset_x    (offset_x_q),
		.offset_y    (offset_y_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.point_count (point_count),
		.last_point  (last_point)
	);

endmodule

`default_nettype wire

>>> sim/grid_path_corner_extract_denorm_tb.sv
module grid_path_corner_extract_denorm_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gpce_pkg::*;

	localparam int INDEX_BITS     = 20;
	localparam int MAX_GRID_WIDTH = 4096;
	localparam int CLK_PERIOD     = 20;
	localparam int ITEM_TARGET    = 1650;
	localparam int SETTLE_CYCLES  = 64;
	localparam int HOLD_CYCLES    = 600;
	localparam int QUIET_LIMIT    = 5000;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [COUNT_W-1:0]        count;
		logic                      last;
	} kept_point_t;

	// Tracks the path state and the register settings, and holds the kept points still due.
	class kept_point_board;
		logic [31:0]                grid_width;
		logic signed [SCALE_W-1:0]  inv_scale_x;
		logic signed [SCALE_W-1:0]  inv_scale_y;
		logic signed [OFFSET_W-1:0] offset_x;
		logic signed [OFFSET_W-1:0] offset_y;
		int unsigned                held_col, held_row, kept_col, kept_row;
		bit                         held_valid;
		bit                         starts_path;
		int unsigned                kept_total;
		kept_point_t                kept_due[$];
		int                         errors, cells_taken, points_checked, paths_closed;

		function new();
			grid_width  = 32'd1;
			inv_scale_x = INV_SCALE_RESET;
			inv_scale_y = INV_SCALE_RESET;
			offset_x    = OFFSET_RESET;
			offset_y    = OFFSET_RESET;
			starts_path = 1'b1;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				REG_GRID_WIDTH:  grid_width  = data[31:0];
				REG_INV_SCALE_X: inv_scale_x = data[SCALE_W-1:0];
				REG_INV_SCALE_Y: inv_scale_y = data[SCALE_W-1:0];
				REG_OFFSET_X:    offset_x    = data[OFFSET_W-1:0];
				REG_OFFSET_Y:    offset_y    = data[OFFSET_W-1:0];
				default: ;
			endcase
		endfunction

		// Zero is taken as one and anything past the largest width as that width.
		function int unsigned span();
			if (grid_width == 0) return 1;
			if (grid_width > MAX_GRID_WIDTH) return MAX_GRID_WIDTH;
			return grid_width;
		endfunction

		function int pending();
			return kept_due.size();
		endfunction

		// (cell + 0.5) * inverse scale + offset in Q.17, rounded half away from zero.
		function logic signed [COORD_W-1:0] denorm_coord(int unsigned grid_pos,
				logic signed [SCALE_W-1:0] inv, logic signed [OFFSET_W-1:0] off);
			longint unsigned norm, mag, hi, lo, prod;
			longint          sum, r;
			norm = (longint'(grid_pos) << 1) + 1;
			mag  = (inv < 0) ? -longint'(inv) : longint'(inv);
			hi   = (norm >> 17) * mag;
			lo   = (norm & 64'h1FFFF) * mag;
			// A product this large lands far outside 32 bits; a fixed huge value stands in.
			prod = (hi > (64'd1 << 34)) ? (64'd1 << 51) : ((hi << 17) + lo);
			sum  = (inv < 0) ? -longint'(prod) : longint'(prod);
			sum  = sum + longint'(off) * 2;
			if (sum >= 0) r = (sum + 65536) >>> 17;
			else r = -((-sum + 65536) >>> 17);
			if (r > 64'sd2147483647) r = 64'sd2147483647;
			if (r < -64'sd2147483648) r = -64'sd2147483648;
			return r[COORD_W-1:0];
		endfunction

		function void keep(int unsigned col, int unsigned row, bit fin);
			kept_point_t p;
			if (kept_total < 65535) kept_total++;
			p.x     = denorm_coord(col, inv_scale_x, offset_x);
			p.y     = denorm_coord(row, inv_scale_y, offset_y);
			p.count = kept_total[COUNT_W-1:0];
			p.last  = fin;
			kept_due.push_back(p);
			kept_col = col;
			kept_row = row;
		endfunction

		// Notes one accepted cell and queues the points it lets go.
		function void take_cell(logic [INDEX_BITS-1:0] idx, logic fin);
			int unsigned gw, col, row;
			longint      bend;
			gw  = span();
			col = idx % gw;
			row = idx / gw;
			cells_taken++;
			if (fin) paths_closed++;
			if (starts_path) begin
				kept_total  = 0;
				keep(col, row, fin);
				held_valid  = 1'b0;
				starts_path = fin;
				return;
			end
			// The held point survives only if it bends the line from the last kept point.
			if (held_valid) begin
				bend = (longint'(held_col) - longint'(kept_col)) * (longint'(row) - longint'(kept_row))
					- (longint'(held_row) - longint'(kept_row)) * (longint'(col) - longint'(kept_col));
				if (bend != 0) keep(held_col, held_row, 1'b0);
			end
			if (fin) begin
				keep(col, row, 1'b1);
				held_valid  = 1'b0;
				starts_path = 1'b1;
			end else begin
				held_col   = col;
				held_row   = row;
				held_valid = 1'b1;
			end
		endfunction

		function void check_kept(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
				logic [COUNT_W-1:0] count, logic last);
			kept_point_t want;
			points_checked++;
			if (kept_due.size() == 0) begin
				$error("kept point (%0d, %0d) count %0d arrived with none expected", x, y, count);
				errors++;
				return;
			end
			want = kept_due.pop_front();
			if (x !== want.x) begin
				$error("coord_x: expected %0d, got %0d", want.x, x);
				errors++;
			end
			if (y !== want.y) begin
				$error("coord_y: expected %0d, got %0d", want.y, y);
				errors++;
			end
			if (count !== want.count) begin
				$error("point_count: expected %0d, got %0d", want.count, count);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_point: expected %0b, got %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [INDEX_BITS-1:0]     cell_index;
	logic                      path_end;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic [COUNT_W-1:0]        point_count;
	logic                      last_point;
	logic                      cfg_we;
	logic [CFG_INDEX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	kept_point_board board = new();
	bit  hold_out_req;
	int  quiet_cycles;
	int  burst_left;
	int  cells_offered;
	int  settings_used;

	grid_path_corner_extract_denorm #(
		.INDEX_BITS     (INDEX_BITS),
		.MAX_GRID_WIDTH (MAX_GRID_WIDTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cell_index  (cell_index),
		.path_end    (path_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.point_count (point_count),
		.last_point  (last_point),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watches both channels and the register port at each edge; the watchdog sits last.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) board.check_kept(coord_x, coord_y, point_count, last_point);
			if (in_valid && in_ready) board.take_cell(cell_index, path_end);
			if (cfg_we) board.write_reg(cfg_index, cfg_data);
			if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// The receiver switches between stall patterns and honors one long hold-off on request.
	initial begin
		int mode_left;
		int stall_pct;
		mode_left = 0;
		stall_pct = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_out_req) begin
				hold_out_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 200);
				case ($urandom_range(4))
					0, 1: stall_pct = 0;
					2: stall_pct = 25;
					3: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			mode_left--;
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic pause_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Offers one cell and returns at the edge that takes the beat.
	task automatic offer_cell(input logic [INDEX_BITS-1:0] idx, input logic fin);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(3) != 0) pause_sender($urandom_range(1, 60));
		end
		burst_left--;
		cells_offered++;
		in_valid   <= 1'b1;
		cell_index <= idx;
		path_end   <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stops the sender until every kept point due has come out and the block has gone quiet.
	task automatic settle();
		pause_sender(1);
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic configure(input logic [12:0] gw, input logic signed [SCALE_W-1:0] sx,
			input logic signed [SCALE_W-1:0] sy, input logic signed [OFFSET_W-1:0] ox,
			input logic signed [OFFSET_W-1:0] oy);
		settle();
		write_reg(REG_GRID_WIDTH, CFG_DATA_W'(gw));
		write_reg(REG_INV_SCALE_X, CFG_DATA_W'(sx));
		write_reg(REG_INV_SCALE_Y, CFG_DATA_W'(sy));
		write_reg(REG_OFFSET_X, CFG_DATA_W'(ox));
		write_reg(REG_OFFSET_Y, CFG_DATA_W'(oy));
		// An index past the last register must change nothing.
		write_reg(CFG_INDEX_W'(REG_OFFSET_Y + $urandom_range(1, 3)),
			CFG_DATA_W'({$urandom, $urandom}));
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	function automatic logic [12:0] pick_grid_width();
		case ($urandom_range(9))
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'($urandom_range(2, 8));
			3, 4: return 13'($urandom_range(9, 64));
			5: return 13'($urandom_range(65, 1024));
			6: return 13'($urandom_range(1025, MAX_GRID_WIDTH - 1));
			7: return 13'(MAX_GRID_WIDTH);
			8: return 13'($urandom_range(MAX_GRID_WIDTH + 1, 8191));
			default: return 13'($urandom_range(2, 16));
		endcase
	endfunction

	function automatic logic signed [SCALE_W-1:0] pick_scale();
		int m;
		m = int'($urandom_range(1, 32'h4_0000));
		case ($urandom_range(7))
			0: return $urandom;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh8000_0000;
			3: return 32'sd0;
			default: return $urandom_range(1) ? -m : m;
		endcase
	endfunction

	function automatic logic signed [OFFSET_W-1:0] pick_offset();
		logic signed [OFFSET_W-1:0] v;
		v = OFFSET_W'({$urandom, $urandom});
		case ($urandom_range(7))
			0: return v;
			1: return 48'sh7FFF_FFFF_FFFF;
			2: return 48'sh8000_0000_0000;
			3: return 48'sd0;
			default: return v >>> 16;
		endcase
	endfunction

	// A path of straight runs in random directions, so corners and collinear points mix.
	task automatic send_walk(input int n_cells);
		int egw, max_row, col, row, dx, dy, run_left, stride;
		egw      = board.span();
		max_row  = (1 << INDEX_BITS) / egw - 1;
		col      = $urandom_range(1) ? 0 : $urandom_range(egw - 1);
		row      = $urandom_range(3) == 0 ? max_row : $urandom_range(max_row);
		run_left = 0;
		dx       = 0;
		dy       = 0;
		for (int i = 0; i < n_cells; i++) begin
			if (run_left == 0) begin
				stride   = ($urandom_range(3) == 0) ? $urandom_range(1, 200) : 1;
				dx       = (int'($urandom_range(6)) - 3) * stride;
				dy       = (int'($urandom_range(6)) - 3) * stride;
				run_left = $urandom_range(1, 6);
			end
			run_left--;
			if (i > 0) begin
				col = col + dx;
				row = row + dy;
				if (col < 0) col = 0;
				if (col > egw - 1) col = egw - 1;
				if (row < 0) row = 0;
				if (row > max_row) row = max_row;
			end
			offer_cell(INDEX_BITS'(row * egw + col), i == n_cells - 1);
		end
	endtask

	// Holds the output off while cells keep coming, so the block backs up into its input.
	task automatic back_up_output();
		settle();
		hold_out_req = 1'b1;
		burst_left   = 40;
		for (int i = 0; i < 36; i++) offer_cell(INDEX_BITS'($urandom), i == 35);
	endtask

	initial begin
		int  phase_goal;
		bit  backed_up;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cell_index = '0;
		path_end   = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		backed_up  = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: single-point paths at both index extremes, then a straight path.
		offer_cell('0, 1'b1);
		offer_cell('1, 1'b1);
		offer_cell(INDEX_BITS'(5), 1'b0);
		offer_cell(INDEX_BITS'(6), 1'b0);
		offer_cell(INDEX_BITS'(7), 1'b1);

		// Widest grid, largest scales and offsets: a right-angle turn and the far corner.
		configure(13'(MAX_GRID_WIDTH), 32'sh7FFF_FFFF, 32'sh8000_0000,
			48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000);
		offer_cell(INDEX_BITS'(0), 1'b0);
		offer_cell(INDEX_BITS'(4), 1'b0);
		offer_cell(INDEX_BITS'(3 * 4096 + 4), 1'b0);
		offer_cell(INDEX_BITS'(7 * 4096 + 4), 1'b1);
		offer_cell('1, 1'b1);

		// Zero width, zero x scale with a negative offset of -3.5, and a huge y product.
		configure(13'd0, 32'sd0, 32'sh7FFF_FFFF, -48'sd229376, 48'sd32768);
		offer_cell('1, 1'b1);
		offer_cell(INDEX_BITS'(0), 1'b0);
		offer_cell(INDEX_BITS'(0), 1'b0);
		offer_cell(INDEX_BITS'(9), 1'b1);

		// Width past the largest one and negative unit scales: a diagonal, then a kink.
		configure(13'd8191, -32'sd65536, -32'sd65536, 48'sd0, 48'sd0);
		offer_cell(INDEX_BITS'(0), 1'b0);
		offer_cell(INDEX_BITS'(4097), 1'b0);
		offer_cell(INDEX_BITS'(8194), 1'b0);
		offer_cell(INDEX_BITS'(12291), 1'b0);
		offer_cell(INDEX_BITS'(12300), 1'b1);

		// Random phases, each under fresh settings and ending on a closed path.
		while (cells_offered < ITEM_TARGET) begin
			configure(pick_grid_width(), pick_scale(), pick_scale(), pick_offset(), pick_offset());
			if (!backed_up && cells_offered > ITEM_TARGET / 3) begin
				back_up_output();
				backed_up = 1'b1;
			end
			phase_goal = cells_offered + $urandom_range(120, 260);
			if (phase_goal > ITEM_TARGET) phase_goal = ITEM_TARGET;
			while (cells_offered < phase_goal) begin
				case ($urandom_range(9))
					0: offer_cell(INDEX_BITS'($urandom), $urandom_range(5) == 0);
					1: send_walk(1);
					2: send_walk($urandom_range(13, 40));
					default: send_walk($urandom_range(2, 12));
				endcase
			end
			settle();
			if (!board.starts_path) offer_cell(INDEX_BITS'($urandom), 1'b1);
		end

		settle();
		$display("Covered %0d cells in %0d paths under %0d register settings;",
			board.cells_taken, board.paths_closed, settings_used + 1);
		$display("%0d kept points checked, with one long output hold-off.", board.points_checked);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/gpce_pkg.sv
rtl/gpce_front.sv
rtl/gpce_fifo.sv
rtl/gpce_back.sv
rtl/grid_path_corner_extract_denorm.sv
sim/grid_path_corner_extract_denorm_tb.sv
